// File: hw/rtl/papc_pkg.sv
// Package for the periodic alarm persistence check.
// Holds register indexes, entry modes, widths and the field selection helpers.
// No dependencies.
`default_nettype none

package papc_pkg;

    localparam int CNT_W      = 16;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int STATUS_W   = 32;
    localparam int ENTRY_W    = 2;
    localparam int LSTATE_W   = 4;
    localparam int LTIME_W    = 16;
    localparam int LTIME_Q_W  = 13;
    localparam int MODES_W    = 8;
    localparam int MODE_W     = 2;
    localparam int MUL_W      = 32;
    localparam int DIV10_SH   = 19;

    localparam logic [CNT_W-1:0]    CNT_MAX        = 16'hFFFF;
    localparam logic [LSTATE_W-1:0] LINK_MIN_STATE = 4'd4;
    localparam logic [16:0]         DIV10_RECIP    = 17'd52429;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHECK_PERIODS    = 3'd0,
        REG_RUN_THRESHOLDS   = 3'd1,
        REG_FAULT_MASKS_LOW  = 3'd2,
        REG_FAULT_MASKS_HIGH = 3'd3,
        REG_ENTRY_MODES      = 3'd4
    } cfg_reg_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_BIT_SET   = 2'd0,
        MODE_BIT_CLEAR = 2'd1,
        MODE_LINK      = 2'd2,
        MODE_RESERVED  = 2'd3
    } entry_mode_t;

    typedef struct packed {
        logic [CNT_W-1:0] cyc_next;
        logic [CNT_W-1:0] run_next;
        logic             alarm;
        logic             sampled;
    } eval_res_t;

    function automatic logic [CNT_W-1:0] field16(input logic [CFG_W-1:0] packed_w,
                                                 input logic [ENTRY_W-1:0] e);
        return packed_w[{e, 4'b0000} +: CNT_W];
    endfunction

    function automatic logic [STATUS_W-1:0] mask_sel(input logic [CFG_W-1:0] lo,
                                                     input logic [CFG_W-1:0] hi,
                                                     input logic [ENTRY_W-1:0] e);
        logic [CFG_W-1:0] w;
        w = e[1] ? hi : lo;
        return e[0] ? w[CFG_W-1:STATUS_W] : w[STATUS_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/papc_eval.sv
// Per-tick evaluation of one alarm entry: period gate, fault test, run count.
// Purely combinational; depends on papc_pkg.
`default_nettype none

module papc_eval (
    input  wire logic [papc_pkg::CNT_W-1:0]     cyc,
    input  wire logic [papc_pkg::CNT_W-1:0]     run,
    input  wire logic [papc_pkg::CNT_W-1:0]     period,
    input  wire logic [papc_pkg::CNT_W-1:0]     thr,
    input  wire logic [papc_pkg::STATUS_W-1:0]  mask,
    input  wire logic [papc_pkg::MODE_W-1:0]    mode,
    input  wire logic [papc_pkg::STATUS_W-1:0]  status_word,
    input  wire logic                           link_sync,
    input  wire logic [papc_pkg::LSTATE_W-1:0]  link_state,
    input  wire logic [papc_pkg::LTIME_Q_W-1:0] ltime_q,
    output papc_pkg::eval_res_t                 res
);

    logic [papc_pkg::CNT_W-1:0] cyc_inc;
    logic [papc_pkg::CNT_W-1:0] run_upd;
    logic [papc_pkg::CNT_W:0]   ext_thr;
    logic                       hit;
    logic                       fault;

    assign cyc_inc = papc_pkg::sat_inc(cyc);
    assign hit     = (status_word & mask) != '0;
    assign ext_thr = {1'b0, thr} + {{(papc_pkg::CNT_W + 1 - papc_pkg::LTIME_Q_W){1'b0}}, ltime_q};

    always_comb
    begin
        case (mode)
            papc_pkg::MODE_LINK:      fault = link_sync & hit;
            papc_pkg::MODE_BIT_CLEAR: fault = ~hit;
            default:                  fault = hit;
        endcase
    end

    assign run_upd = fault ? papc_pkg::sat_inc(run) : '0;

    always_comb
    begin
        res.cyc_next = '0;
        res.run_next = run_upd;
        res.alarm    = 1'b0;
        res.sampled  = 1'b1;
        if (cyc_inc < period)
        begin
            res.cyc_next = cyc_inc;
            res.run_next = run;
            res.sampled  = 1'b0;
        end
        else if (run_upd >= thr)
        begin
            if (mode == papc_pkg::MODE_LINK && link_state < papc_pkg::LINK_MIN_STATE)
            begin
                res.cyc_next = cyc_inc;
                res.run_next = '0;
            end
            else if (mode == papc_pkg::MODE_LINK && {1'b0, run_upd} < ext_thr)
            begin
                res.cyc_next = cyc_inc;
            end
            else
            begin
                res.alarm    = 1'b1;
                res.run_next = '0;
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/periodic_alarm_persistence_check.sv
// Top level of the periodic alarm persistence check: config registers,
// input and result registers, per-entry counters. Depends on papc_pkg, papc_eval.
//
//   channel | signals                                         | direction
//   in      | in_valid, in_stall, entry, status_word,         | into block
//           | link_sync, link_state, link_stable_time         |
//   out     | out_valid, out_stall, alarm_raised,             | out of block
//           | alarm_entry, sampled                            |
//   cfg     | cfg_we, cfg_index, cfg_data                     | into block
//
// One transaction per cycle sustained while out_stall is low; the path is the input
// register, then evaluation against the counters into the result register.
// The divide of link_stable_time by ten is a reciprocal multiply before the
// input register. Reset clears config, counters and valid flags.
// in_stall rises only while a held result is stalled and the input register is full.
`default_nettype none

module periodic_alarm_persistence_check #(
    parameter int NUM_ALARMS = 4
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [papc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [papc_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [papc_pkg::ENTRY_W-1:0]      entry,
    input  wire logic [papc_pkg::STATUS_W-1:0]     status_word,
    input  wire logic                              link_sync,
    input  wire logic [papc_pkg::LSTATE_W-1:0]     link_state,
    input  wire logic [papc_pkg::LTIME_W-1:0]      link_stable_time,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   alarm_raised,
    output logic [papc_pkg::ENTRY_W-1:0]           alarm_entry,
    output logic                                   sampled
);

    localparam int IDX_W = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;

    logic [papc_pkg::CFG_W-1:0]     periods_reg;
    logic [papc_pkg::CFG_W-1:0]     thresholds_reg;
    logic [papc_pkg::CFG_W-1:0]     masks_low_reg;
    logic [papc_pkg::CFG_W-1:0]     masks_high_reg;
    logic [papc_pkg::MODES_W-1:0]   modes_reg;

    logic [papc_pkg::CNT_W-1:0]     cyc_reg [NUM_ALARMS];
    logic [papc_pkg::CNT_W-1:0]     run_reg [NUM_ALARMS];

    logic                           iv_reg;
    logic [papc_pkg::ENTRY_W-1:0]   ientry_reg;
    logic [papc_pkg::STATUS_W-1:0]  istatus_reg;
    logic                           isync_reg;
    logic [papc_pkg::LSTATE_W-1:0]  istate_reg;
    logic [papc_pkg::LTIME_Q_W-1:0] iltq_reg;

    logic                           ov_reg;
    logic                           oalarm_reg;
    logic [papc_pkg::ENTRY_W-1:0]   oentry_reg;
    logic                           osampled_reg;

    logic [papc_pkg::MUL_W-1:0]     ltime_prod;
    logic [papc_pkg::LTIME_Q_W-1:0] ltime_q_next;
    logic                           advance;
    logic                           in_range;
    logic                           commit;
    logic [IDX_W-1:0]               idx;
    papc_pkg::eval_res_t            res;

    assign ltime_prod   = {{(papc_pkg::MUL_W - papc_pkg::LTIME_W){1'b0}}, link_stable_time}
                          * {{(papc_pkg::MUL_W - 17){1'b0}}, papc_pkg::DIV10_RECIP};
    assign ltime_q_next = ltime_prod[papc_pkg::DIV10_SH +: papc_pkg::LTIME_Q_W];

    assign advance  = ~ov_reg | ~out_stall;
    assign in_stall = iv_reg & ~advance;
    assign commit   = iv_reg & advance;
    assign in_range = {1'b0, ientry_reg} < 3'(NUM_ALARMS);
    assign idx      = IDX_W'(ientry_reg);

    papc_eval u_eval (
        .cyc         (cyc_reg[idx]),
        .run         (run_reg[idx]),
        .period      (papc_pkg::field16(periods_reg, ientry_reg)),
        .thr         (papc_pkg::field16(thresholds_reg, ientry_reg)),
        .mask        (papc_pkg::mask_sel(masks_low_reg, masks_high_reg, ientry_reg)),
        .mode        (modes_reg[{ientry_reg, 1'b0} +: papc_pkg::MODE_W]),
        .status_word (istatus_reg),
        .link_sync   (isync_reg),
        .link_state  (istate_reg),
        .ltime_q     (iltq_reg),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            periods_reg    <= '0;
            thresholds_reg <= '0;
            masks_low_reg  <= '0;
            masks_high_reg <= '0;
            modes_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                papc_pkg::REG_CHECK_PERIODS:    periods_reg    <= cfg_data;
                papc_pkg::REG_RUN_THRESHOLDS:   thresholds_reg <= cfg_data;
                papc_pkg::REG_FAULT_MASKS_LOW:  masks_low_reg  <= cfg_data;
                papc_pkg::REG_FAULT_MASKS_HIGH: masks_high_reg <= cfg_data;
                papc_pkg::REG_ENTRY_MODES:      modes_reg      <= cfg_data[papc_pkg::MODES_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ALARMS; i++)
            begin
                cyc_reg[i] <= '0;
                run_reg[i] <= '0;
            end
        end
        else if (commit && in_range)
        begin
            cyc_reg[idx] <= res.cyc_next;
            run_reg[idx] <= res.run_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                iv_reg <= in_valid;
            end
            if (advance)
            begin
                ov_reg <= iv_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            ientry_reg  <= entry;
            istatus_reg <= status_word;
            isync_reg   <= link_sync;
            istate_reg  <= link_state;
            iltq_reg    <= ltime_q_next;
        end
        if (commit)
        begin
            oentry_reg   <= ientry_reg;
            oalarm_reg   <= in_range & res.alarm;
            osampled_reg <= in_range & res.sampled;
        end
    end

    assign out_valid    = ov_reg;
    assign alarm_raised = oalarm_reg;
    assign alarm_entry  = oentry_reg;
    assign sampled      = osampled_reg;

    a_alarm_needs_sample: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!alarm_raised || sampled))
        else $error("alarm raised without a sample");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (iv_reg && ov_reg && out_stall))
        else $error("input stalled without a held result");

    a_alarm_clears_run: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && in_range && res.alarm) |=> (run_reg[$past(idx)] == '0))
        else $error("run counter not cleared after alarm");

    a_out_of_range_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ({1'b0, alarm_entry} >= 3'(NUM_ALARMS))) |-> (!sampled && !alarm_raised))
        else $error("entry beyond range produced a sample");

endmodule

`default_nettype wire
